// ===== design/bcmd_pkg.sv =====
// ----------------------------------------------------------------------------
// bcmd_pkg
// Shared types and constants for the byte command motor drive unit.
// ----------------------------------------------------------------------------
package bcmd_pkg;

  // Motion codes as seen on the result channel
  typedef enum logic [2:0] {
    MOT_STOP  = 3'd0,
    MOT_FWD   = 3'd1,
    MOT_BACK  = 3'd2,
    MOT_LEFT  = 3'd3,
    MOT_RIGHT = 3'd4
  } motion_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MAX_DUTY    = 2'd0,
    REG_MIN_DUTY    = 2'd1,
    REG_DUTY_STEP   = 2'd2,
    REG_FAILSAFE_MS = 2'd3
  } reg_idx_t;

  // Item operation codes
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // Command characters (upper case after folding)
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Duty limits and configuration reset values
  localparam logic [6:0]  DUTY_CAP        = 7'd100;
  localparam logic [6:0]  RST_MAX_DUTY    = 7'd100;
  localparam logic [6:0]  RST_MIN_DUTY    = 7'd10;
  localparam logic [6:0]  RST_DUTY_STEP   = 7'd5;
  localparam logic [15:0] RST_FAILSAFE_MS = 16'd2000;

  // One result item
  typedef struct packed {
    motion_t     motion;
    logic [7:0]  left_drive;
    logic [7:0]  right_drive;
    logic [6:0]  duty;
    logic        changed;
    logic        failsafe_fired;
    logic [31:0] rx_total;
    logic [31:0] error_total;
    logic [31:0] failsafe_total;
  } result_t;

endpackage

// ===== design/byte_command_motor_drive_unit.sv =====
// ----------------------------------------------------------------------------
// byte_command_motor_drive_unit
// Serial command byte interpreter and failsafe timer for a two-motor drive.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (in_valid/in_ready): either a received command byte
//   (in_operation = 0) or a failsafe check (in_operation = 1), each with
//   the current millisecond time in in_now_ms.
//   Result channel (out_valid/out_ready): one result item per input item,
//   carrying motion, signed left/right drive, duty, flags and the three
//   wrapping counters.
//   Configuration (cfg_we/cfg_index/cfg_wdata): duty limits, duty step and
//   failsafe time; write only while no item is in flight.
// Timing:
//   An item's state update is done in the cycle it is accepted; its result
//   is registered at the same edge, into the skid stage if the output stalls.
//   One item per cycle is taken while in_ready is high (single update pass).
// Reset:
//   rst_n low clears state, counters and config to their reset values and
//   empties the output register and skid stage.
// Stall:
//   A two-entry output (result register plus skid stage) keeps in_ready
//   high while one result waits; in_ready drops only when both are full.
// ----------------------------------------------------------------------------
module byte_command_motor_drive_unit #(
  parameter int unsigned START_DUTY = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_rx_byte,
  input  logic [31:0] in_now_ms,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_motion,
  output logic [7:0]  out_left_drive,
  output logic [7:0]  out_right_drive,
  output logic [6:0]  out_duty,
  output logic        out_changed,
  output logic        out_failsafe_fired,
  output logic [31:0] out_rx_total,
  output logic [31:0] out_error_total,
  output logic [31:0] out_failsafe_total
);
  import bcmd_pkg::*;

  // configuration registers
  logic [6:0]  max_duty_r, min_duty_r, duty_step_r;
  logic [15:0] failsafe_ms_r;

  // drive state
  motion_t     motion_r, motion_nxt;
  logic [6:0]  duty_r, duty_nxt;
  logic [31:0] last_cmd_r, last_cmd_nxt;
  logic [7:0]  left_r, left_nxt, right_r, right_nxt;
  logic [31:0] rx_cnt_r, rx_cnt_nxt;
  logic [31:0] err_cnt_r, err_cnt_nxt;
  logic [31:0] fs_cnt_r, fs_cnt_nxt;

  // output register and skid stage
  result_t     out_r, skid_r, res_nxt;
  logic        out_v_r, skid_v_r;

  logic        in_fire, out_fire;
  logic [7:0]  cmd_byte;
  logic [6:0]  hi_lim, lo_lim;
  logic [7:0]  up_sum, lo_sum;
  logic [6:0]  duty_up, duty_dn;
  logic [31:0] age;
  logic        apply, changed, fired;
  motion_t     mot_sel;
  logic [7:0]  pos_d, neg_d;

  assign in_ready = !skid_v_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_v_r && out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_duty_r    <= RST_MAX_DUTY;
      min_duty_r    <= RST_MIN_DUTY;
      duty_step_r   <= RST_DUTY_STEP;
      failsafe_ms_r <= RST_FAILSAFE_MS;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MAX_DUTY:    max_duty_r    <= cfg_wdata[6:0];
        REG_MIN_DUTY:    min_duty_r    <= cfg_wdata[6:0];
        REG_DUTY_STEP:   duty_step_r   <= cfg_wdata[6:0];
        REG_FAILSAFE_MS: failsafe_ms_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // duty stepping arithmetic, limits capped at full duty
  always_comb begin
    hi_lim  = (max_duty_r > DUTY_CAP) ? DUTY_CAP : max_duty_r;
    lo_lim  = (min_duty_r > DUTY_CAP) ? DUTY_CAP : min_duty_r;
    up_sum  = {1'b0, duty_r} + {1'b0, duty_step_r};
    lo_sum  = {1'b0, lo_lim} + {1'b0, duty_step_r};
    duty_up = (up_sum <= {1'b0, hi_lim}) ? up_sum[6:0] : hi_lim;
    duty_dn = ({1'b0, duty_r} >= lo_sum) ? (duty_r - duty_step_r) : lo_lim;
    age     = in_now_ms - last_cmd_r;
  end

  // command decode and state update for one item
  always_comb begin
    motion_nxt   = motion_r;
    duty_nxt     = duty_r;
    last_cmd_nxt = last_cmd_r;
    left_nxt     = left_r;
    right_nxt    = right_r;
    rx_cnt_nxt   = rx_cnt_r;
    err_cnt_nxt  = err_cnt_r;
    fs_cnt_nxt   = fs_cnt_r;
    apply        = 1'b0;
    changed      = 1'b0;
    fired        = 1'b0;
    mot_sel      = MOT_STOP;

    // fold lower case to upper case
    cmd_byte = in_rx_byte;
    if (in_rx_byte >= CH_LC_A && in_rx_byte <= CH_LC_Z) begin
      cmd_byte = in_rx_byte - CASE_OFS;
    end

    if (in_operation == OP_BYTE) begin
      rx_cnt_nxt = rx_cnt_r + 32'd1;
      case (cmd_byte)
        CH_F: begin
          last_cmd_nxt = in_now_ms; mot_sel = MOT_FWD; apply = 1'b1; changed = 1'b1;
        end
        CH_B: begin
          last_cmd_nxt = in_now_ms; mot_sel = MOT_BACK; apply = 1'b1; changed = 1'b1;
        end
        CH_L: begin
          last_cmd_nxt = in_now_ms; mot_sel = MOT_LEFT; apply = 1'b1; changed = 1'b1;
        end
        CH_R: begin
          last_cmd_nxt = in_now_ms; mot_sel = MOT_RIGHT; apply = 1'b1; changed = 1'b1;
        end
        CH_S, CH_X, CH_ZERO: begin
          mot_sel = MOT_STOP; apply = 1'b1; changed = 1'b1;
        end
        CH_PLUS, CH_MINUS: begin
          duty_nxt = (cmd_byte == CH_PLUS) ? duty_up : duty_dn;
          // reapply current motion at the new duty
          if (motion_r != MOT_STOP) begin
            last_cmd_nxt = in_now_ms;
            mot_sel      = motion_r;
            apply        = 1'b1;
          end
          changed = 1'b1;
        end
        CH_CR, CH_LF, CH_SPACE, CH_TAB: ;
        default: err_cnt_nxt = err_cnt_r + 32'd1;
      endcase
    end else begin
      // failsafe check: stale command while moving forces a stop
      if (motion_r != MOT_STOP && age >= {16'd0, failsafe_ms_r}) begin
        mot_sel    = MOT_STOP;
        apply      = 1'b1;
        fired      = 1'b1;
        changed    = 1'b1;
        fs_cnt_nxt = fs_cnt_r + 32'd1;
      end
    end

    // drive mapping at the (possibly updated) duty
    pos_d = {1'b0, duty_nxt};
    neg_d = 8'd0 - pos_d;
    if (apply) begin
      motion_nxt = mot_sel;
      case (mot_sel)
        MOT_FWD:   begin left_nxt = pos_d; right_nxt = pos_d; end
        MOT_BACK:  begin left_nxt = neg_d; right_nxt = neg_d; end
        MOT_LEFT:  begin left_nxt = neg_d; right_nxt = pos_d; end
        MOT_RIGHT: begin left_nxt = pos_d; right_nxt = neg_d; end
        default:   begin left_nxt = 8'd0;  right_nxt = 8'd0; motion_nxt = MOT_STOP; end
      endcase
    end

    res_nxt.motion         = motion_nxt;
    res_nxt.left_drive     = left_nxt;
    res_nxt.right_drive    = right_nxt;
    res_nxt.duty           = duty_nxt;
    res_nxt.changed        = changed;
    res_nxt.failsafe_fired = fired;
    res_nxt.rx_total       = rx_cnt_nxt;
    res_nxt.error_total    = err_cnt_nxt;
    res_nxt.failsafe_total = fs_cnt_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motion_r   <= MOT_STOP;
      duty_r     <= START_DUTY[6:0];
      last_cmd_r <= 32'd0;
      left_r     <= 8'd0;
      right_r    <= 8'd0;
      rx_cnt_r   <= 32'd0;
      err_cnt_r  <= 32'd0;
      fs_cnt_r   <= 32'd0;
    end else if (in_fire) begin
      motion_r   <= motion_nxt;
      duty_r     <= duty_nxt;
      last_cmd_r <= last_cmd_nxt;
      left_r     <= left_nxt;
      right_r    <= right_nxt;
      rx_cnt_r   <= rx_cnt_nxt;
      err_cnt_r  <= err_cnt_nxt;
      fs_cnt_r   <= fs_cnt_nxt;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (in_fire) begin
        if (out_v_r && !out_ready) begin
          skid_v_r <= 1'b1;
        end else begin
          out_v_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_v_r  <= skid_v_r;
        skid_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (out_v_r && !out_ready) begin
        skid_r <= res_nxt;
      end else begin
        out_r <= res_nxt;
      end
    end else if (out_fire && skid_v_r) begin
      out_r <= skid_r;
    end
  end

  assign out_valid          = out_v_r;
  assign out_motion         = out_r.motion;
  assign out_left_drive     = out_r.left_drive;
  assign out_right_drive    = out_r.right_drive;
  assign out_duty           = out_r.duty;
  assign out_changed        = out_r.changed;
  assign out_failsafe_fired = out_r.failsafe_fired;
  assign out_rx_total       = out_r.rx_total;
  assign out_error_total    = out_r.error_total;
  assign out_failsafe_total = out_r.failsafe_total;

endmodule

// ===== design/bcmd_checker.sv =====
// ----------------------------------------------------------------------------
// bcmd_checker
// Port-level checks for the byte command motor drive unit.
// ----------------------------------------------------------------------------
module bcmd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_motion,
  input logic [7:0]  out_left_drive,
  input logic [7:0]  out_right_drive,
  input logic        out_changed,
  input logic        out_failsafe_fired
);
  import bcmd_pkg::*;

  // no result straight out of reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_motion)
      && $stable(out_left_drive) && $stable(out_right_drive))
    else $error("stalled result changed");

  // a forced stop is a change and leaves the drive stopped
  a_fire_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_failsafe_fired |-> out_changed && out_motion == MOT_STOP)
    else $error("failsafe result not a stop");

  // stopped means both motors at zero
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_motion == MOT_STOP |-> out_left_drive == 8'd0
      && out_right_drive == 8'd0)
    else $error("drive non-zero while stopped");

endmodule

bind byte_command_motor_drive_unit bcmd_checker u_bcmd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_motion         (out_motion),
  .out_left_drive     (out_left_drive),
  .out_right_drive    (out_right_drive),
  .out_changed        (out_changed),
  .out_failsafe_fired (out_failsafe_fired)
);
